FILE: rtl/core/omw_pkg.sv
package omw_pkg;

   // Field widths
   localparam int HEADING_W = 11;
   localparam int CMD_W     = 13;
   localparam int TICKS_W   = 16;
   localparam int WHEEL_W   = 14;
   localparam int RAMP_W    = 14;
   localparam int STEP_W    = 26;
   localparam int WIDE_W    = 28;

   // Register widths and reset values
   localparam int SPEED_LIMIT_W = 12;
   localparam int DEADBAND_W    = 8;
   localparam int ACCEL_W       = 10;
   localparam int RAMP_LIMIT_W  = 13;
   localparam int CSR_DATA_W    = 13;
   localparam int CSR_INDEX_W   = 2;

   localparam logic [SPEED_LIMIT_W-1:0] SPEED_LIMIT_RST = 12'd4000;
   localparam logic [DEADBAND_W-1:0]    DEADBAND_RST    = 8'd20;
   localparam logic [ACCEL_W-1:0]       ACCEL_RST       = 10'd70;
   localparam logic [RAMP_LIMIT_W-1:0]  RAMP_LIMIT_RST  = 13'd4096;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_SPEED_LIMIT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEADBAND    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACCEL       = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_RAMP_LIMIT  = 2'd3;

   // Sine format
   localparam int SINE_FRAC_BITS_DEF = 15;
   localparam int SINE_ENTRIES       = 91;
   localparam int SINE_IDX_W         = 7;
   localparam int ANGLE_W            = 9;

   localparam logic [63:0] PI_Q30  = 64'd3373259426;
   localparam logic [63:0] ONE_Q30 = 64'd1073741824;

   // Wheel angle biases: wheel angle = -heading + bias (mod 360)
   localparam int BIAS_ONE   = -135;
   localparam int BIAS_TWO   = -45;
   localparam int BIAS_THREE = -315;
   localparam int BIAS_FOUR  = -225;

   // Clamped command split into sign and magnitude
   typedef struct packed {
      logic             neg;
      logic [CMD_W-1:0] mag;
   } cmd_type;

   // Ramp settings
   typedef struct packed {
      logic [DEADBAND_W-1:0]   deadband;
      logic [ACCEL_W-1:0]      accel;
      logic [RAMP_LIMIT_W-1:0] limit;
   } ramp_cfg_type;

   // sin of k degrees (0..90), unsigned with frac fraction bits; elaboration only
   function automatic logic [31:0] sine_q(input int k, input int frac);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] sum;
      logic [63:0] r;
      if (k == 0) begin
         return 32'd0;
      end
      if (k >= 90) begin
         return 32'(64'd1 << frac);
      end
      x    = (64'(k) * PI_Q30) / 64'd180;
      x2   = (x * x) >> 30;
      sum  = x;
      term = ((x * x2) >> 30) / 64'd6;
      sum  = sum - term;
      term = ((term * x2) >> 30) / 64'd20;
      sum  = sum + term;
      term = ((term * x2) >> 30) / 64'd42;
      sum  = sum - term;
      term = ((term * x2) >> 30) / 64'd72;
      sum  = sum + term;
      term = ((term * x2) >> 30) / 64'd110;
      sum  = sum - term;
      term = ((term * x2) >> 30) / 64'd156;
      sum  = sum + term;
      term = ((term * x2) >> 30) / 64'd210;
      sum  = sum - term;
      term = ((term * x2) >> 30) / 64'd272;
      sum  = sum + term;
      if (sum > ONE_Q30) begin
         sum = ONE_Q30;
      end
      r = (sum + (64'd1 << (29 - frac))) >> (30 - frac);
      if (r > (64'd1 << frac)) begin
         r = 64'd1 << frac;
      end
      return 32'(r);
   endfunction

endpackage

FILE: rtl/core/omni_wheel_mix_with_ramp_unit.sv
// Four-wheel omni drive mixer with a ramped speed tracker.
//
// Input channel (req_*): heading in degrees, signed command speed and the
// ticks elapsed since the previous command. Result channel (rsp_*): four
// wheel speeds (offsets +45, +135, -135, -45 degrees on the mirrored heading,
// scaled by the clamped command) and the ramped speed after this item.
// Both channels use valid/stall; an item moves when valid is high and stall
// is low.
//
// The input register feeds the result register, which drives rsp_valid.
// Throughput is one item per cycle while rsp_stall is low, set by the single
// pass through the sine tables, the four wheel multipliers and the ramp
// update.
// When the receiver stalls, the result register holds and the input register
// still takes one more item; req_stall rises only when both are full.
//
// Reset (synchronous, active high) empties both registers, sets the ramped
// speed to zero and loads the default register values. The user must write the
// registers via csr_write/index/wdata only while the block is idle (unchecked).
module omni_wheel_mix_with_ramp_unit #(
   parameter int SINE_FRAC_BITS = omw_pkg::SINE_FRAC_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // configuration
   input  logic                                 csr_write,
   input  logic [omw_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [omw_pkg::CSR_DATA_W-1:0]       csr_wdata,
   // input channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [omw_pkg::HEADING_W-1:0] req_heading_deg,
   input  logic signed [omw_pkg::CMD_W-1:0]     req_command_speed,
   input  logic [omw_pkg::TICKS_W-1:0]          req_elapsed_ticks,
   // result channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [omw_pkg::WHEEL_W-1:0]   rsp_wheel_one,
   output logic signed [omw_pkg::WHEEL_W-1:0]   rsp_wheel_two,
   output logic signed [omw_pkg::WHEEL_W-1:0]   rsp_wheel_three,
   output logic signed [omw_pkg::WHEEL_W-1:0]   rsp_wheel_four,
   output logic signed [omw_pkg::RAMP_W-1:0]    rsp_ramped_speed
);

   localparam int HV_W = 12;

   // configuration registers
   logic [omw_pkg::SPEED_LIMIT_W-1:0] speed_limit_ff;
   logic [omw_pkg::DEADBAND_W-1:0]    deadband_ff;
   logic [omw_pkg::ACCEL_W-1:0]       accel_ff;
   logic [omw_pkg::RAMP_LIMIT_W-1:0]  ramp_limit_ff;

   // input register
   logic                                 in_valid_ff;
   logic signed [omw_pkg::HEADING_W-1:0] heading_ff;
   logic signed [omw_pkg::CMD_W-1:0]     command_ff;
   logic [omw_pkg::TICKS_W-1:0]          ticks_ff;

   // result register and ramp state
   logic                                 out_valid_ff;
   logic signed [omw_pkg::WHEEL_W-1:0]   wheel_one_ff;
   logic signed [omw_pkg::WHEEL_W-1:0]   wheel_two_ff;
   logic signed [omw_pkg::WHEEL_W-1:0]   wheel_three_ff;
   logic signed [omw_pkg::WHEEL_W-1:0]   wheel_four_ff;
   logic signed [omw_pkg::RAMP_W-1:0]    ramp_speed_ff;
   logic signed [omw_pkg::RAMP_W-1:0]    ramp_speed_in;

   logic                                 out_load;
   logic                                 in_load;
   logic signed [omw_pkg::CMD_W-1:0]     cmd_clamped;
   omw_pkg::cmd_type                     cmd_split;
   omw_pkg::ramp_cfg_type                ramp_cfg;
   logic [HV_W-1:0]                      heading_biased;
   logic [omw_pkg::ANGLE_W-1:0]          heading_mod;
   logic signed [omw_pkg::WHEEL_W-1:0]   wheel_one;
   logic signed [omw_pkg::WHEEL_W-1:0]   wheel_two;
   logic signed [omw_pkg::WHEEL_W-1:0]   wheel_three;
   logic signed [omw_pkg::WHEEL_W-1:0]   wheel_four;

   // flow control
   assign out_load  = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign in_load   = req_valid && !req_stall;
   assign req_stall = in_valid_ff && !out_load;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         speed_limit_ff <= omw_pkg::SPEED_LIMIT_RST;
         deadband_ff    <= omw_pkg::DEADBAND_RST;
         accel_ff       <= omw_pkg::ACCEL_RST;
         ramp_limit_ff  <= omw_pkg::RAMP_LIMIT_RST;
      end else if (csr_write) begin
         case (csr_index)
            omw_pkg::CSR_SPEED_LIMIT: begin
               speed_limit_ff <= omw_pkg::SPEED_LIMIT_W'(csr_wdata);
            end
            omw_pkg::CSR_DEADBAND: begin
               deadband_ff <= omw_pkg::DEADBAND_W'(csr_wdata);
            end
            omw_pkg::CSR_ACCEL: begin
               accel_ff <= omw_pkg::ACCEL_W'(csr_wdata);
            end
            omw_pkg::CSR_RAMP_LIMIT: begin
               ramp_limit_ff <= omw_pkg::RAMP_LIMIT_W'(csr_wdata);
            end
            default: begin
            end
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_load) begin
         in_valid_ff <= 1'b1;
      end else if (out_load) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load) begin
         heading_ff <= req_heading_deg;
         command_ff <= req_command_speed;
         ticks_ff   <= req_elapsed_ticks;
      end
   end

   // command clamp and sign/magnitude split
   always_comb begin
      if (command_ff > $signed({1'b0, speed_limit_ff})) begin
         cmd_clamped = $signed({1'b0, speed_limit_ff});
      end else begin
         cmd_clamped = command_ff;
      end
      cmd_split.neg = cmd_clamped[omw_pkg::CMD_W-1];
      cmd_split.mag = cmd_clamped[omw_pkg::CMD_W-1] ? omw_pkg::CMD_W'(-cmd_clamped)
                                                    : omw_pkg::CMD_W'(cmd_clamped);
   end

   // heading mod 360: bias by 1080 into 56..2103, then subtract the right multiple
   assign heading_biased = HV_W'(heading_ff) + HV_W'(1080);

   always_comb begin
      if (heading_biased >= HV_W'(1800)) begin
         heading_mod = omw_pkg::ANGLE_W'(heading_biased - HV_W'(1800));
      end else if (heading_biased >= HV_W'(1440)) begin
         heading_mod = omw_pkg::ANGLE_W'(heading_biased - HV_W'(1440));
      end else if (heading_biased >= HV_W'(1080)) begin
         heading_mod = omw_pkg::ANGLE_W'(heading_biased - HV_W'(1080));
      end else if (heading_biased >= HV_W'(720)) begin
         heading_mod = omw_pkg::ANGLE_W'(heading_biased - HV_W'(720));
      end else if (heading_biased >= HV_W'(360)) begin
         heading_mod = omw_pkg::ANGLE_W'(heading_biased - HV_W'(360));
      end else begin
         heading_mod = omw_pkg::ANGLE_W'(heading_biased);
      end
   end

   // four wheel lanes
   omw_wheel #(.SINE_FRAC_BITS(SINE_FRAC_BITS), .ANGLE_BIAS(omw_pkg::BIAS_ONE)) u_wheel_one (
      .heading_mod (heading_mod),
      .cmd         (cmd_split),
      .wheel       (wheel_one)
   );

   omw_wheel #(.SINE_FRAC_BITS(SINE_FRAC_BITS), .ANGLE_BIAS(omw_pkg::BIAS_TWO)) u_wheel_two (
      .heading_mod (heading_mod),
      .cmd         (cmd_split),
      .wheel       (wheel_two)
   );

   omw_wheel #(.SINE_FRAC_BITS(SINE_FRAC_BITS), .ANGLE_BIAS(omw_pkg::BIAS_THREE)) u_wheel_three (
      .heading_mod (heading_mod),
      .cmd         (cmd_split),
      .wheel       (wheel_three)
   );

   omw_wheel #(.SINE_FRAC_BITS(SINE_FRAC_BITS), .ANGLE_BIAS(omw_pkg::BIAS_FOUR)) u_wheel_four (
      .heading_mod (heading_mod),
      .cmd         (cmd_split),
      .wheel       (wheel_four)
   );

   // ramp update
   assign ramp_cfg.deadband = deadband_ff;
   assign ramp_cfg.accel    = accel_ff;
   assign ramp_cfg.limit    = ramp_limit_ff;

   omw_ramp u_ramp (
      .cfg        (ramp_cfg),
      .cmd        (cmd_clamped),
      .ticks      (ticks_ff),
      .speed      (ramp_speed_ff),
      .speed_next (ramp_speed_in)
   );

   // result register; ramp state advances with each item loaded into it
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         ramp_speed_ff <= '0;
      end else begin
         if (out_load) begin
            out_valid_ff  <= 1'b1;
            ramp_speed_ff <= ramp_speed_in;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         wheel_one_ff   <= wheel_one;
         wheel_two_ff   <= wheel_two;
         wheel_three_ff <= wheel_three;
         wheel_four_ff  <= wheel_four;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_wheel_one    = wheel_one_ff;
   assign rsp_wheel_two    = wheel_two_ff;
   assign rsp_wheel_three  = wheel_three_ff;
   assign rsp_wheel_four   = wheel_four_ff;
   assign rsp_ramped_speed = ramp_speed_ff;

endmodule

FILE: rtl/core/omw_wheel.sv
module omw_wheel #(
   parameter int SINE_FRAC_BITS = omw_pkg::SINE_FRAC_BITS_DEF,
   parameter int ANGLE_BIAS     = omw_pkg::BIAS_ONE
) (
   input  logic [omw_pkg::ANGLE_W-1:0]  heading_mod,
   input  omw_pkg::cmd_type             cmd,
   output logic signed [omw_pkg::WHEEL_W-1:0] wheel
);

   localparam int SW     = SINE_FRAC_BITS + 1;
   localparam int PROD_W = omw_pkg::CMD_W + SW;
   localparam int T_W    = 11;

   logic [SW-1:0]                     sine_rom [0:omw_pkg::SINE_ENTRIES-1];
   logic [T_W-1:0]                    t_raw;
   logic [omw_pkg::ANGLE_W-1:0]       angle;
   logic [omw_pkg::SINE_IDX_W-1:0]    idx;
   logic                              quad_neg;
   logic [PROD_W-1:0]                 prod;
   logic [omw_pkg::WHEEL_W-1:0]       mag;

   // Constant quarter-wave sine table
   for (genvar gk = 0; gk < omw_pkg::SINE_ENTRIES; gk++) begin : g_rom
      assign sine_rom[gk] = SW'(omw_pkg::sine_q(gk, SINE_FRAC_BITS));
   end

   // Wheel angle in 0..359: 720 + bias - heading lands in 46..675
   assign t_raw = T_W'(720 + ANGLE_BIAS) - T_W'(heading_mod);
   assign angle = (t_raw >= T_W'(360)) ? omw_pkg::ANGLE_W'(t_raw - T_W'(360))
                                       : omw_pkg::ANGLE_W'(t_raw);

   // Quadrant fold
   always_comb begin
      if (angle <= 9'd90) begin
         idx      = omw_pkg::SINE_IDX_W'(angle);
         quad_neg = 1'b0;
      end else if (angle <= 9'd180) begin
         idx      = omw_pkg::SINE_IDX_W'(9'd180 - angle);
         quad_neg = 1'b0;
      end else if (angle <= 9'd270) begin
         idx      = omw_pkg::SINE_IDX_W'(angle - 9'd180);
         quad_neg = 1'b1;
      end else begin
         idx      = omw_pkg::SINE_IDX_W'(9'd360 - angle);
         quad_neg = 1'b1;
      end
   end

   // Magnitude product, truncated toward zero, then sign applied
   assign prod  = PROD_W'(cmd.mag) * PROD_W'(sine_rom[idx]);
   assign mag   = omw_pkg::WHEEL_W'(prod >> SINE_FRAC_BITS);
   assign wheel = (quad_neg ^ cmd.neg) ? -$signed(mag) : $signed(mag);

endmodule

FILE: rtl/core/omw_ramp.sv
module omw_ramp (
   input  omw_pkg::ramp_cfg_type                 cfg,
   input  logic signed [omw_pkg::CMD_W-1:0]      cmd,
   input  logic [omw_pkg::TICKS_W-1:0]           ticks,
   input  logic signed [omw_pkg::RAMP_W-1:0]     speed,
   output logic signed [omw_pkg::RAMP_W-1:0]     speed_next
);

   localparam int W = omw_pkg::WIDE_W;

   logic [omw_pkg::STEP_W-1:0] step;
   logic signed [W-1:0]        step_w;
   logic signed [W-1:0]        cmd_w;
   logic signed [W-1:0]        s_w;
   logic signed [W-1:0]        db_w;
   logic signed [W-1:0]        lim_w;
   logic signed [W-1:0]        n_w;

   // Ramp step for the elapsed time, full width
   assign step   = omw_pkg::STEP_W'(cfg.accel) * omw_pkg::STEP_W'(ticks);
   assign step_w = $signed(W'(step));
   assign cmd_w  = W'(cmd);
   assign s_w    = W'(speed);
   assign db_w   = $signed(W'(cfg.deadband));
   assign lim_w  = $signed(W'(cfg.limit));

   // Move toward the command; leaving zero always takes a unit step
   always_comb begin
      n_w = s_w;
      if (cmd_w < db_w && cmd_w > -db_w) begin
         n_w = '0;
      end else if (cmd_w > s_w) begin
         if (s_w < 0) begin
            n_w = s_w + step_w;
            if (cmd_w < n_w) n_w = cmd_w;
         end else if (s_w > 0) begin
            n_w = s_w + step_w;
            if (n_w > lim_w) n_w = lim_w;
            if (cmd_w < n_w) n_w = cmd_w;
         end
         if (n_w == 0) n_w = W'(1);
      end else if (cmd_w < s_w) begin
         if (s_w < 0) begin
            n_w = s_w - step_w;
            if (n_w < -lim_w) n_w = -lim_w;
            if (cmd_w > n_w) n_w = cmd_w;
         end else if (s_w > 0) begin
            n_w = s_w - step_w;
            if (cmd_w > n_w) n_w = cmd_w;
         end
         if (n_w == 0) n_w = -W'(1);
      end
   end

   assign speed_next = omw_pkg::RAMP_W'(n_w);

endmodule

FILE: bench/omw_drive_checker.sv
// Watches the config port and both channels, predicts the four wheel speeds
// and the ramped speed for every accepted command, and compares each result.
module omw_drive_checker #(
   parameter int SINE_FRAC = omw_pkg::SINE_FRAC_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write,
   input  logic [omw_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [omw_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  logic                                 req_valid,
   input  logic                                 req_stall,
   input  logic signed [omw_pkg::HEADING_W-1:0] req_heading_deg,
   input  logic signed [omw_pkg::CMD_W-1:0]     req_command_speed,
   input  logic [omw_pkg::TICKS_W-1:0]          req_elapsed_ticks,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   input  logic signed [omw_pkg::WHEEL_W-1:0]   rsp_wheel_one,
   input  logic signed [omw_pkg::WHEEL_W-1:0]   rsp_wheel_two,
   input  logic signed [omw_pkg::WHEEL_W-1:0]   rsp_wheel_three,
   input  logic signed [omw_pkg::WHEEL_W-1:0]   rsp_wheel_four,
   input  logic signed [omw_pkg::RAMP_W-1:0]    rsp_ramped_speed,
   output int                                   n_pending,
   output int                                   n_checked,
   output int                                   n_mismatch
);
   import omw_pkg::*;

   typedef struct packed {
      logic [WHEEL_W-1:0] wheel_one;
      logic [WHEEL_W-1:0] wheel_two;
      logic [WHEEL_W-1:0] wheel_three;
      logic [WHEEL_W-1:0] wheel_four;
      logic [RAMP_W-1:0]  ramped_speed;
   } drive_set_type;

   // local copy of the block's settings and ramp state
   logic [SPEED_LIMIT_W-1:0] lim_speed;
   logic [DEADBAND_W-1:0]    dead_zone;
   logic [ACCEL_W-1:0]       accel_step;
   logic [RAMP_LIMIT_W-1:0]  ramp_cap;
   longint                   ramp_now;

   longint        quarter_sine [0:90];
   drive_set_type drive_sets_due [$];

   // sin of 0..90 degrees: Q30 Taylor series, rounded to SINE_FRAC bits
   initial begin
      logic [63:0] ang;
      logic [63:0] ang_sq;
      logic [63:0] term;
      logic [63:0] acc;
      quarter_sine[0]  = 0;
      quarter_sine[90] = longint'(1) << SINE_FRAC;
      for (int k = 1; k < 90; k++) begin
         ang    = (64'(k) * PI_Q30) / 64'd180;
         ang_sq = (ang * ang) >> 30;
         term   = ang;
         acc    = ang;
         for (int n = 1; n <= 8; n++) begin
            term = ((term * ang_sq) >> 30) / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1)
               acc = acc - term;
            else
               acc = acc + term;
         end
         if (acc > ONE_Q30)
            acc = ONE_Q30;
         acc = (acc + (64'd1 << (29 - SINE_FRAC))) >> (30 - SINE_FRAC);
         if (acc > (64'd1 << SINE_FRAC))
            acc = 64'd1 << SINE_FRAC;
         quarter_sine[k] = longint'(acc);
      end
   end

   // sin(angle) * cmd, truncated toward zero, wrapped to the wheel width
   function automatic logic [WHEEL_W-1:0] wheel_speed(longint angle, longint cmd);
      longint deg;
      longint mag;
      logic   neg;
      deg = (angle + 3600) % 360;
      neg = 1'b0;
      if (deg <= 90) begin
         mag = quarter_sine[deg];
      end else if (deg <= 180) begin
         mag = quarter_sine[180 - deg];
      end else if (deg <= 270) begin
         mag = quarter_sine[deg - 180];
         neg = 1'b1;
      end else begin
         mag = quarter_sine[360 - deg];
         neg = 1'b1;
      end
      if (cmd < 0)
         neg = !neg;
      mag = ((cmd < 0 ? -cmd : cmd) * mag) >>> SINE_FRAC;
      return neg ? WHEEL_W'(-mag) : WHEEL_W'(mag);
   endfunction

   // next ramp value and the wheel mix for one command
   function automatic drive_set_type predict_drive(logic signed [HEADING_W-1:0] heading,
                                                   logic signed [CMD_W-1:0] command,
                                                   logic [TICKS_W-1:0] ticks);
      longint        cmd;
      longint        top_speed;
      longint        band;
      longint        cap;
      longint        delta;
      longint        s;
      longint        angle;
      drive_set_type r;
      cmd       = command;
      top_speed = lim_speed;
      band      = dead_zone;
      cap       = ramp_cap;
      delta     = longint'(accel_step) * longint'(ticks);
      if (cmd > top_speed)
         cmd = top_speed;

      s = ramp_now;
      if (cmd < band && cmd > -band) begin
         s = 0;
      end else if (cmd > s) begin
         if (s < 0) begin
            s = s + delta;
            if (s > cmd)
               s = cmd;
         end else if (s > 0) begin
            s = s + delta;
            if (s > cap)
               s = cap;
            if (s > cmd)
               s = cmd;
         end
         // leaving zero goes by one count
         if (s == 0)
            s = 1;
      end else if (cmd < s) begin
         if (s > 0) begin
            s = s - delta;
            if (s < cmd)
               s = cmd;
         end else if (s < 0) begin
            s = s - delta;
            if (s < -cap)
               s = -cap;
            if (s < cmd)
               s = cmd;
         end
         if (s == 0)
            s = -1;
      end
      ramp_now = s;

      // mirrored heading, wheels driven from the clamped command
      angle         = -(longint'(heading) + 180);
      r.wheel_one   = wheel_speed(angle + 45, cmd);
      r.wheel_two   = wheel_speed(angle + 135, cmd);
      r.wheel_three = wheel_speed(angle - 135, cmd);
      r.wheel_four  = wheel_speed(angle - 45, cmd);
      r.ramped_speed = RAMP_W'(s);
      return r;
   endfunction

   task automatic flag_mismatch(string note);
      $display("ERROR @%0t: %s", $realtime, note);
      n_mismatch++;
   endtask

   task automatic match_field(string what, logic [WHEEL_W-1:0] got, logic [WHEEL_W-1:0] want);
      if (got !== want)
         flag_mismatch($sformatf("result %0d %s: got %0d, want %0d",
                                 n_checked, what, $signed(got), $signed(want)));
   endtask

   // settings, predictions and comparisons, all sampled at the rising edge
   always @(posedge clock) begin
      drive_set_type want;
      if (reset) begin
         lim_speed  = SPEED_LIMIT_RST;
         dead_zone  = DEADBAND_RST;
         accel_step = ACCEL_RST;
         ramp_cap   = RAMP_LIMIT_RST;
         ramp_now   = 0;
         drive_sets_due.delete();
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_SPEED_LIMIT: lim_speed  = csr_wdata[SPEED_LIMIT_W-1:0];
               CSR_DEADBAND:    dead_zone  = csr_wdata[DEADBAND_W-1:0];
               CSR_ACCEL:       accel_step = csr_wdata[ACCEL_W-1:0];
               CSR_RAMP_LIMIT:  ramp_cap   = csr_wdata[RAMP_LIMIT_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            drive_sets_due.push_back(predict_drive(req_heading_deg, req_command_speed,
                                                   req_elapsed_ticks));
         if (rsp_valid && !rsp_stall) begin
            if (drive_sets_due.size() == 0) begin
               flag_mismatch("result with no command outstanding");
            end else begin
               want = drive_sets_due.pop_front();
               match_field("wheel_one", rsp_wheel_one, want.wheel_one);
               match_field("wheel_two", rsp_wheel_two, want.wheel_two);
               match_field("wheel_three", rsp_wheel_three, want.wheel_three);
               match_field("wheel_four", rsp_wheel_four, want.wheel_four);
               match_field("ramped_speed", rsp_ramped_speed, want.ramped_speed);
            end
            n_checked++;
         end
      end
      n_pending = drive_sets_due.size();
   end

endmodule

FILE: bench/tb_omni_wheel_mix_with_ramp_unit.sv
module tb_omni_wheel_mix_with_ramp_unit;
   import omw_pkg::*;

   localparam int IDLE_LIMIT = 1000;

   logic                        clock;
   logic                        reset;
   logic                        csr_write;
   logic [CSR_INDEX_W-1:0]      csr_index;
   logic [CSR_DATA_W-1:0]       csr_wdata;
   logic                        req_valid;
   logic                        req_stall;
   logic signed [HEADING_W-1:0] req_heading_deg;
   logic signed [CMD_W-1:0]     req_command_speed;
   logic [TICKS_W-1:0]          req_elapsed_ticks;
   logic                        rsp_valid;
   logic                        rsp_stall;
   logic signed [WHEEL_W-1:0]   rsp_wheel_one;
   logic signed [WHEEL_W-1:0]   rsp_wheel_two;
   logic signed [WHEEL_W-1:0]   rsp_wheel_three;
   logic signed [WHEEL_W-1:0]   rsp_wheel_four;
   logic signed [RAMP_W-1:0]    rsp_ramped_speed;

   int n_pending;
   int n_checked;
   int n_mismatch;
   int n_items;
   int n_settings;
   bit eager;

   omni_wheel_mix_with_ramp_unit DUT (
      .clock             (clock),
      .reset             (reset),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_heading_deg   (req_heading_deg),
      .req_command_speed (req_command_speed),
      .req_elapsed_ticks (req_elapsed_ticks),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_wheel_one     (rsp_wheel_one),
      .rsp_wheel_two     (rsp_wheel_two),
      .rsp_wheel_three   (rsp_wheel_three),
      .rsp_wheel_four    (rsp_wheel_four),
      .rsp_ramped_speed  (rsp_ramped_speed)
   );

   omw_drive_checker drive_check (
      .clock             (clock),
      .reset             (reset),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_heading_deg   (req_heading_deg),
      .req_command_speed (req_command_speed),
      .req_elapsed_ticks (req_elapsed_ticks),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_wheel_one     (rsp_wheel_one),
      .rsp_wheel_two     (rsp_wheel_two),
      .rsp_wheel_three   (rsp_wheel_three),
      .rsp_wheel_four    (rsp_wheel_four),
      .rsp_ramped_speed  (rsp_ramped_speed),
      .n_pending         (n_pending),
      .n_checked         (n_checked),
      .n_mismatch        (n_mismatch)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // receiver stalls: alternating free and stalled runs, now and then a long calm
   initial begin
      int  run_len;
      int  roll;
      logic stalled;
      rsp_stall = 1'b0;
      stalled   = 1'b0;
      run_len   = 0;
      forever begin
         @(negedge clock);
         if (run_len == 0) begin
            stalled = !stalled;
            roll    = $urandom_range(0, 99);
            if (!stalled)
               run_len = (roll < 90) ? $urandom_range(1, 6) : $urandom_range(30, 150);
            else if (roll < 80)
               run_len = $urandom_range(1, 3);
            else if (roll < 96)
               run_len = $urandom_range(4, 10);
            else
               run_len = $urandom_range(20, 60);
         end
         rsp_stall <= stalled;
         run_len--;
      end
   end

   // one command; called at a falling edge, returns at the falling edge after acceptance
   task automatic send_item(int heading, int command, int ticks);
      int gap;
      int roll;
      roll = $urandom_range(0, 99);
      if (eager || roll < 45)
         gap = 0;
      else if (roll < 88)
         gap = $urandom_range(1, 3);
      else if (roll < 97)
         gap = $urandom_range(4, 12);
      else
         gap = $urandom_range(20, 60);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_heading_deg   <= HEADING_W'(heading);
      req_command_speed <= CMD_W'(command);
      req_elapsed_ticks <= TICKS_W'(ticks);
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      n_items++;
   endtask

   task automatic wait_all_returned();
      req_valid <= 1'b0;
      do @(negedge clock); while (n_pending != 0);
   endtask

   // all four registers on consecutive cycles, block idle
   task automatic write_settings(int top_speed, int band, int accel, int cap);
      int                     vals [4];
      logic [CSR_INDEX_W-1:0] regs [4];
      vals = '{top_speed, band, accel, cap};
      regs = '{CSR_SPEED_LIMIT, CSR_DEADBAND, CSR_ACCEL, CSR_RAMP_LIMIT};
      csr_write <= 1'b1;
      for (int i = 0; i < 4; i++) begin
         csr_index <= regs[i];
         csr_wdata <= CSR_DATA_W'(vals[i]);
         @(negedge clock);
      end
      csr_write <= 1'b0;
      n_settings++;
   endtask

   // register value: mostly in range, sometimes an end or stray upper bits
   function automatic int pick_reg(int high);
      int roll;
      roll = $urandom_range(0, 9);
      if (roll == 0)
         return 0;
      if (roll == 1)
         return high;
      if (roll == 2)
         return $urandom_range(0, 8191);
      return $urandom_range(0, high);
   endfunction

   function automatic int pick_heading();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll < 6)
         return $urandom_range(0, 1440) - 720;
      if (roll < 9)
         return 45 * $urandom_range(0, 32) - 720 + $urandom_range(0, 2) - 1;
      return $urandom_range(0, 2047) - 1024;
   endfunction

   function automatic int pick_command();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll == 0)
         return $urandom_range(0, 8191) - 4096;
      if (roll == 1)
         return $urandom_range(0, 1) ? 4095 : -4096;
      if (roll < 5)
         return $urandom_range(0, 600) - 300;
      return $urandom_range(0, 8191) - 4096;
   endfunction

   function automatic int pick_ticks();
      int roll;
      roll = $urandom_range(0, 19);
      if (roll < 12)
         return $urandom_range(0, 20);
      if (roll < 16)
         return $urandom_range(21, 1000);
      if (roll < 19)
         return $urandom_range(0, 65535);
      return $urandom_range(0, 1) ? 65535 : 0;
   endfunction

   // ramp runs: a command held over several items, with some stray commands
   task automatic run_random(int count);
      int left_in_run;
      int held_cmd;
      left_in_run = 0;
      held_cmd    = 0;
      repeat (count) begin
         if (left_in_run == 0) begin
            left_in_run = $urandom_range(1, 12);
            held_cmd    = pick_command();
         end
         left_in_run--;
         if ($urandom_range(0, 9) < 8)
            send_item(pick_heading(), held_cmd, pick_ticks());
         else
            send_item(pick_heading(), pick_command(), pick_ticks());
      end
   endtask

   // stall on either channel or a lost result ends the run here
   initial begin
      int idle_run;
      idle_run = 0;
      while (idle_run < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_run = 0;
         else
            idle_run++;
      end
      $display("timeout: no handshake for %0d cycles, %0d results outstanding",
               IDLE_LIMIT, n_pending);
      $display("** omni_wheel_mix_with_ramp_unit: FAILED **");
      $finish;
   end

   initial begin
      reset             = 1'b1;
      csr_write         = 1'b0;
      csr_index         = CSR_SPEED_LIMIT;
      csr_wdata         = '0;
      req_valid         = 1'b0;
      req_heading_deg   = '0;
      req_command_speed = '0;
      req_elapsed_ticks = '0;
      n_items           = 0;
      n_settings        = 1;
      eager             = 1'b0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // reset settings: field ends, deadband edges, each ramp branch
      send_item(0, 0, 0);
      send_item(90, 4095, 1);
      send_item(-90, 4095, 10);
      send_item(45, 4095, 65535);
      send_item(180, 4095, 3);
      send_item(-180, -4096, 1);
      send_item(720, -4096, 65535);
      send_item(-720, -4096, 5);
      send_item(1023, 4095, 0);
      send_item(-1024, 100, 57);
      send_item(135, 100, 1);
      send_item(-135, 100, 1);
      send_item(-45, 19, 9);
      send_item(270, -19, 9);
      send_item(-270, -20, 9);
      send_item(360, 20, 0);
      send_item(-360, 20, 1);
      send_item(1, 21, 2);
      send_item(89, -21, 0);
      send_item(91, -4095, 1);
      send_item(-359, -4096, 65535);
      send_item(-1, 1, 0);
      run_random(150);

      // full scale, zero with full deadband, tight limits, then random settings
      for (int p = 0; p < 7; p++) begin
         wait_all_returned();
         eager = (p == 0) || ($urandom_range(0, 3) == 0);
         case (p)
            0: write_settings(4095, 0, 1023, 8191);
            1: write_settings(0, 255, 0, 0);
            2: write_settings(100, 1, 1, 50);
            default: write_settings(pick_reg(4095), pick_reg(255), pick_reg(1023), pick_reg(8191));
         endcase
         run_random(p == 1 ? 100 : 150);
      end

      wait_all_returned();
      repeat (4) @(negedge clock);

      $display("%0d commands over %0d register settings (reset, full scale, zero, tight, random)",
               n_items, n_settings);
      $display("%0d drive results compared, %0d mismatches", n_checked, n_mismatch);
      if (n_mismatch == 0)
         $display("** omni_wheel_mix_with_ramp_unit: PASSED **");
      else
         $display("** omni_wheel_mix_with_ramp_unit: FAILED **");
      $finish;
   end

endmodule
